// ===== rtl/core/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared widths, register and action codes, and the constant-divide tables
// of the cosine series evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

   localparam int MAX_TERMS_DEF = 16;

   localparam int IDX_W      = 5;
   localparam int COEF_W     = 24;
   localparam int T_W        = 32;
   localparam int SERIES_W   = 40;
   localparam int PH_W       = 32;
   localparam int COS_W      = 18;
   localparam int NT_W       = 5;
   localparam int TURNS_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;

   localparam logic [NT_W-1:0]    NT_RESET    = 5'd10;
   localparam logic [TURNS_W-1:0] TURNS_RESET = 32'd1884137728;
   localparam logic [31:0]        TWO_PI_Q29  = 32'hC90F_DAA2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TERMS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURNS     = 2'd1;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL  = 1'b1;

   // low 32 bits of floor(2^shift / d) + 1; the top bit (2^32) is always set
   function automatic logic [31:0] div_magic(input logic use_sin, input logic [1:0] step);
      logic [31:0] val;
      case ({use_sin, step})
         3'b000:  val = 32'h2492_4925;
         3'b001:  val = 32'h1111_1112;
         3'b010:  val = 32'h5555_5556;
         3'b011:  val = 32'h0000_0001;
         3'b100:  val = 32'hC71C_71C8;
         3'b101:  val = 32'h8618_6187;
         3'b110:  val = 32'h9999_999A;
         3'b111:  val = 32'h5555_5556;
         default: val = 32'h0000_0001;
      endcase
      return val;
   endfunction

   function automatic logic [5:0] div_shift(input logic use_sin, input logic [1:0] step);
      logic [5:0] val;
      case ({use_sin, step})
         3'b000:  val = 6'd38;
         3'b001:  val = 6'd37;
         3'b010:  val = 6'd36;
         3'b011:  val = 6'd33;
         3'b100:  val = 6'd39;
         3'b101:  val = 6'd38;
         3'b110:  val = 6'd37;
         3'b111:  val = 6'd35;
         default: val = 6'd33;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cse_ifs.sv =====
// ----------------------------------------------------------------------------
// cse_req_if / cse_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cse_req_if;
   import cse_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [IDX_W-1:0]         coef_index;
   logic signed [COEF_W-1:0] coef_value;
   logic signed [T_W-1:0]    t_value;

   modport source (output valid, action, coef_index, coef_value, t_value, input ready);
   modport sink   (input valid, action, coef_index, coef_value, t_value, output ready);
endinterface

interface cse_rsp_if;
   import cse_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SERIES_W-1:0] series_value;

   modport source (output valid, series_value, input ready);
   modport sink   (input valid, series_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cse_ram.sv =====
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cosine_series_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// cosine_series_evaluator_top
// Truncated Fourier cosine series C0 + 2*sum(Ci*cos(i*t/alpha)) in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per valid/ready handshake. A write item
//   (action = 0) stores coef_value at coef_index and gives no result; an
//   index above MAX_TERMS is dropped. An evaluate item (action = 1) sums
//   harmonics 0..min(K, MAX_TERMS) at t_value and gives one item on rsp_chan.
//   csr_we/csr_index/csr_wdata set num_terms (K, index 0) and turns_per_unit
//   (index 1); write them only while the block is idle.
//   One shared 33x33 multiplier does all products; each of its 10 to 11 uses
//   per term has an issue state and a post-processing state.
//   req_chan.ready is high only while no evaluation is in flight.
//   Reset clears the coefficient table (by valid bits), loads the register
//   defaults and drops any pending result. When rsp_chan stalls, the result
//   holds in the output register and the next evaluation waits before its
//   final rounding step; write items are still taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_series_evaluator_top #(
   parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   cse_req_if.sink                         req_chan,
   cse_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [cse_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cse_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import cse_pkg::*;

   localparam int AW    = $clog2(MAX_TERMS + 1);
   localparam int CW    = (AW > IDX_W) ? AW : IDX_W;
   localparam int ACC_W = COEF_W + COS_W + $clog2(MAX_TERMS + 1);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_INIT    = 5'd1;
   localparam logic [4:0] ST_PHASE   = 5'd2;
   localparam logic [4:0] ST_FOLD    = 5'd3;
   localparam logic [4:0] ST_XMUL    = 5'd4;
   localparam logic [4:0] ST_XPOST   = 5'd5;
   localparam logic [4:0] ST_SQMUL   = 5'd6;
   localparam logic [4:0] ST_SQPOST  = 5'd7;
   localparam logic [4:0] ST_DIVMUL  = 5'd8;
   localparam logic [4:0] ST_DIVPOST = 5'd9;
   localparam logic [4:0] ST_HMUL    = 5'd10;
   localparam logic [4:0] ST_HPOST   = 5'd11;
   localparam logic [4:0] ST_SINMUL  = 5'd12;
   localparam logic [4:0] ST_SINPOST = 5'd13;
   localparam logic [4:0] ST_COS     = 5'd14;
   localparam logic [4:0] ST_CMUL    = 5'd15;
   localparam logic [4:0] ST_ACC     = 5'd16;
   localparam logic [4:0] ST_ROUND   = 5'd17;

   logic [4:0]                 state_ff, state_in;
   logic [NT_W-1:0]            num_terms_ff, num_terms_in;
   logic [TURNS_W-1:0]         turns_ff, turns_in;
   logic [PH_W-1:0]            base_ff, base_in;
   logic [PH_W-1:0]            ph_ff, ph_in;
   logic [29:0]                m_ff, m_in;
   logic                       neg_ff, neg_in;
   logic                       sin_ff, sin_in;
   logic [31:0]                x_ff, x_in;
   logic [31:0]                x2_ff, x2_in;
   logic [31:0]                n_ff, n_in;
   logic [32:0]                h_ff, h_in;
   logic [1:0]                 step_ff, step_in;
   logic signed [COS_W-1:0]    cos_ff, cos_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [AW-1:0]              term_ff, term_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic signed [SERIES_W-1:0] rsp_data_ff, rsp_data_in;
   logic [MAX_TERMS:0]         vld_ff, vld_in;
   logic                       vld_rd_ff, vld_rd_in;

   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic                       req_acc;
   logic [CW-1:0]              nt_ext;
   logic [AW-1:0]              k_sat;
   logic                       wr_en, rd_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [COEF_W-1:0]          rd_data;
   logic signed [COEF_W-1:0]   coef_rd;

   logic [32:0]                f0, f1, f2, f3;
   logic                       fold_neg, fold_sin;
   logic [60:0]                x_rnd;
   logic [64:0]                q_sum, q_shr;
   logic [33:0]                h_rnd;
   logic [16:0]                mag;
   logic [ACC_W:0]             acc_rnd;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.series_value = rsp_data_ff;

   assign nt_ext = CW'(num_terms_ff);
   assign k_sat  = (nt_ext > CW'(MAX_TERMS)) ? AW'(MAX_TERMS) : AW'(nt_ext);
   assign wr_addr = AW'(req_chan.coef_index);
   assign coef_rd = vld_rd_ff ? $signed(rd_data) : '0;

   cse_ram #(
      .WIDTH (COEF_W),
      .DEPTH (MAX_TERMS + 1)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.coef_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      f0 = {1'b0, ph_ff};
      f1 = ph_ff[31] ? (33'h1_0000_0000 - f0) : f0;
      fold_neg = (f1 > 33'h0_4000_0000);
      f2 = fold_neg ? (33'h0_8000_0000 - f1) : f1;
      fold_sin = (f2 > 33'h0_2000_0000);
      f3 = fold_sin ? (33'h0_4000_0000 - f2) : f2;
      x_rnd = prod_ff[60:0] + (61'd1 << 28);
      q_sum = {1'b0, n_ff, 32'd0} + {1'b0, prod_ff[63:0]};
      q_shr = q_sum >> div_shift(sin_ff, step_ff);
      h_rnd = {1'b0, h_ff} + 34'h0_0000_8000;
      mag = h_rnd[32:16];
      acc_rnd = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(17'h0_8000);
   end

   always_comb begin
      mul_a = MUL_W'(req_chan.t_value);
      mul_b = $signed({1'b0, turns_ff});
      case (state_ff)
         ST_XMUL: begin
            mul_a = $signed({3'b000, m_ff});
            mul_b = $signed({1'b0, TWO_PI_Q29});
         end
         ST_SQMUL: begin
            mul_a = $signed({1'b0, x_ff});
            mul_b = $signed({1'b0, x_ff});
         end
         ST_DIVMUL: begin
            mul_a = $signed({1'b0, n_ff});
            mul_b = $signed({1'b0, div_magic(sin_ff, step_ff)});
         end
         ST_HMUL: begin
            mul_a = $signed({1'b0, x2_ff});
            mul_b = $signed({1'b0, h_ff[31:0]});
         end
         ST_SINMUL: begin
            mul_a = $signed({1'b0, x_ff});
            mul_b = $signed({1'b0, h_ff[31:0]});
         end
         ST_CMUL: begin
            mul_a = MUL_W'(coef_rd);
            mul_b = MUL_W'(cos_ff);
         end
         default: begin
            mul_a = MUL_W'(req_chan.t_value);
            mul_b = $signed({1'b0, turns_ff});
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      num_terms_in = num_terms_ff;
      turns_in     = turns_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_TERMS: num_terms_in = csr_wdata[NT_W-1:0];
            CSR_TURNS:     turns_in     = csr_wdata[TURNS_W-1:0];
            default:       num_terms_in = num_terms_ff;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      ph_in       = ph_ff;
      m_in        = m_ff;
      neg_in      = neg_ff;
      sin_in      = sin_ff;
      x_in        = x_ff;
      x2_in       = x2_ff;
      n_in        = n_ff;
      h_in        = h_ff;
      step_in     = step_ff;
      cos_in      = cos_ff;
      acc_in      = acc_ff;
      term_in     = term_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      vld_in      = vld_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = term_ff;

      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.action == ACT_EVAL) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_INIT;
               end else if (CW'(req_chan.coef_index) <= CW'(MAX_TERMS)) begin
                  wr_en           = 1'b1;
                  vld_in[wr_addr] = 1'b1;
               end
            end
         end
         ST_INIT: begin
            base_in  = prod_ff[47:16];
            acc_in   = ACC_W'(coef_rd) <<< 16;
            ph_in    = '0;
            term_in  = AW'(1);
            state_in = (k_sat == '0) ? ST_ROUND : ST_PHASE;
         end
         ST_PHASE: begin
            ph_in    = ph_ff + base_ff;
            rd_en    = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            m_in     = f3[29:0];
            neg_in   = fold_neg;
            sin_in   = fold_sin;
            state_in = ST_XMUL;
         end
         ST_XMUL: begin
            state_in = ST_XPOST;
         end
         ST_XPOST: begin
            x_in     = x_rnd[60:29];
            state_in = ST_SQMUL;
         end
         ST_SQMUL: begin
            state_in = ST_SQPOST;
         end
         ST_SQPOST: begin
            x2_in    = prod_ff[63:32];
            n_in     = prod_ff[63:32];
            step_in  = '0;
            state_in = ST_DIVMUL;
         end
         ST_DIVMUL: begin
            state_in = ST_DIVPOST;
         end
         ST_DIVPOST: begin
            h_in = 33'h1_0000_0000 - {1'b0, q_shr[31:0]};
            if (step_ff == 2'd3) begin
               state_in = sin_ff ? ST_SINMUL : ST_COS;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            state_in = ST_HPOST;
         end
         ST_HPOST: begin
            n_in     = h_ff[32] ? x2_ff : prod_ff[63:32];
            state_in = ST_DIVMUL;
         end
         ST_SINMUL: begin
            state_in = ST_SINPOST;
         end
         ST_SINPOST: begin
            h_in     = {1'b0, (h_ff[32] ? x_ff : prod_ff[63:32])};
            state_in = ST_COS;
         end
         ST_COS: begin
            cos_in   = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + (ACC_W'($signed(prod_ff[COEF_W+COS_W-1:0])) <<< 1);
            if (term_ff == k_sat) begin
               state_in = ST_ROUND;
            end else begin
               term_in  = term_ff + AW'(1);
               state_in = ST_PHASE;
            end
         end
         ST_ROUND: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = SERIES_W'($signed(acc_rnd[ACC_W:16]));
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      vld_rd_in = rd_en ? vld_ff[rd_addr] : vld_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_terms_ff <= NT_RESET;
         turns_ff     <= TURNS_RESET;
         rsp_vld_ff   <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         num_terms_ff <= num_terms_in;
         turns_ff     <= turns_in;
         rsp_vld_ff   <= rsp_vld_in;
         vld_ff       <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      ph_ff       <= ph_in;
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      sin_ff      <= sin_in;
      x_ff        <= x_in;
      x2_ff       <= x2_in;
      n_ff        <= n_in;
      h_ff        <= h_in;
      step_ff     <= step_in;
      cos_ff      <= cos_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
      vld_rd_ff   <= vld_rd_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/cse_chk.sv =====
// ----------------------------------------------------------------------------
// cse_chk
// Port-level checks of the cosine series evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_action,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [cse_pkg::SERIES_W-1:0]     rsp_series_value
);

   import cse_pkg::*;

   a_eval_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_EVAL) |=> !req_ready)
      else $error("evaluate item did not block the request channel");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_WRITE) |=> req_ready)
      else $error("write item blocked the request channel");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item appeared without an evaluation in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_series_value))
      else $error("result item changed while stalled");

endmodule

bind cosine_series_evaluator_top cse_chk u_cse_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_action       (req_chan.action),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_series_value (rsp_chan.series_value)
);

`default_nettype wire

// ===== dv/tb_cosine_series_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// tb_cosine_series_evaluator_top
// Self-checking bench for the cosine series evaluator. A directed table of
// coefficient writes, evaluations and register writes runs first. Random
// phases with different term counts, turn rates and handshake idling follow.
// Every result is compared in order against the expected value of its table
// row, if given, or else a bit-exact fixed-point predictor of the series sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cosine_series_evaluator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cse_pkg::*;

   localparam int TERMS_MAX    = MAX_TERMS_DEF;
   localparam int PHASE_ITEMS  = 222;
   localparam int PHASES       = 6;
   localparam int SETTLE_CYC   = 16;
   localparam int TAIL_CYC     = 450;
   localparam int HOLD_CYC     = 1200;
   localparam int QUIET_LIMIT  = 20000;
   localparam int PLAN_LEN     = 29;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e                  kind;
      logic                       action;
      logic [4:0]                 index;
      logic [31:0]                data;
      logic [31:0]                t_point;
      logic                       typed;
      logic signed [SERIES_W-1:0] series;
   } req_row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cse_req_if req_bus ();
   cse_rsp_if rsp_bus ();

   cosine_series_evaluator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic signed [COEF_W-1:0]   coef_shadow [0:TERMS_MAX];
   logic [NT_W-1:0]            terms_shadow;
   logic [TURNS_W-1:0]         turns_shadow;
   logic signed [SERIES_W-1:0] series_due [$];

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   int  send_idle_pct  = 0;
   int  recv_idle_pct  = 0;
   bit  hold_armed     = 1'b0;

   req_row_t plan [PLAN_LEN] = '{
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 40'sd0},
      '{ROW_ITEM, ACT_WRITE, 5'd0,  32'h007F_FFFF, 32'h0000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 40'sd8388607},
      '{ROW_ITEM, ACT_WRITE, 5'd0,  32'h0080_0000, 32'h0000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1'b1, -40'sd8388608},
      '{ROW_ITEM, ACT_WRITE, 5'd1,  32'h007F_FFFF, 32'h0000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_WRITE, 5'd16, 32'h0080_0000, 32'h0000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_WRITE, 5'd17, 32'h0000_007B, 32'h0000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_WRITE, 5'd31, 32'h00FF_FFFF, 32'h0000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 40'sd8388606},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_NUM_TERMS), 32'hFFFF_FFFF, 32'h0, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, -40'sd8388610},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h8000_0000, 1'b0, 40'sd0},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_TURNS),     32'h0000_0000, 32'h0, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h1234_5678, 1'b1, -40'sd8388610},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_TURNS),     32'hFFFF_FFFF, 32'h0, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h8000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 40'sd0},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_SPARE_2),   32'h0000_0000, 32'h0, 1'b0, 40'sd0},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_SPARE_3),   32'h0000_0001, 32'h0, 1'b0, 40'sd0},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_TURNS),     32'h4000_0000, 32'h0, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h0001_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h0000_8000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_WRITE, 5'd8,  32'h0012_3456, 32'h0000_0000, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h0000_5555, 1'b0, 40'sd0},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_NUM_TERMS), 32'h0000_0000, 32'h0, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1'b1, -40'sd8388608},
      '{ROW_CSR,  ACT_WRITE, 5'(CSR_NUM_TERMS), 32'h0000_0010, 32'h0, 1'b0, 40'sd0},
      '{ROW_ITEM, ACT_EVAL,  5'd0,  32'h0000_0000, 32'hFFFF_0000, 1'b0, 40'sd0}
   };

   function automatic longint harmonic_cos(input logic [PH_W-1:0] phase);
      logic [63:0] m;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] h;
      logic [63:0] mag;
      logic        neg;
      logic        swap;
      int          divs [4];
      m    = {32'd0, phase};
      neg  = 1'b0;
      swap = 1'b0;
      if (m >= 64'h8000_0000) m = Q32_ONE - m;
      if (m > 64'h4000_0000) begin
         neg = 1'b1;
         m   = 64'h8000_0000 - m;
      end
      if (m > 64'h2000_0000) begin
         swap = 1'b1;
         m    = 64'h4000_0000 - m;
      end
      x  = (m * {32'd0, TWO_PI_Q29} + 64'h1000_0000) >> 29;
      x2 = (x * x) >> 32;
      if (swap) divs = '{72, 42, 20, 6};
      else divs = '{56, 30, 12, 2};
      h = Q32_ONE;
      for (int j = 0; j < 4; j++) h = Q32_ONE - ((x2 * h) >> 32) / 64'(divs[j]);
      if (swap) h = (x * h) >> 32;
      mag = (h + 64'h8000) >> 16;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [SERIES_W-1:0] series_at(input logic [T_W-1:0] t_point);
      logic [63:0]     prod;
      logic [PH_W-1:0] base;
      logic [PH_W-1:0] phase;
      longint          acc;
      int              k;
      prod  = {{32{t_point[31]}}, t_point} * {32'd0, turns_shadow};
      base  = prod[47:16];
      k     = (int'(terms_shadow) > TERMS_MAX) ? TERMS_MAX : int'(terms_shadow);
      acc   = longint'(coef_shadow[0]) * 65536;
      phase = '0;
      for (int i = 1; i <= k; i++) begin
         phase = phase + base;
         acc   = acc + 2 * longint'(coef_shadow[i]) * harmonic_cos(phase);
      end
      acc = (acc + 32768) >>> 16;
      return acc[SERIES_W-1:0];
   endfunction

   function automatic req_row_t draw_item();
      req_row_t row;
      int       pick;
      row  = '{ROW_ITEM, ACT_EVAL, 5'd0, 32'd0, 32'd0, 1'b0, 40'sd0};
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         row.action = ACT_WRITE;
         if (pick < 35) row.index = 5'($urandom_range(0, TERMS_MAX));
         else row.index = 5'($urandom_range(TERMS_MAX + 1, 31));
         case ($urandom_range(0, 7))
            0:       row.data = 32'h0080_0000;
            1:       row.data = 32'h007F_FFFF;
            default: row.data = {8'd0, 24'($urandom())};
         endcase
      end else begin
         case ($urandom_range(0, 9))
            0:       row.t_point = 32'h8000_0000;
            1:       row.t_point = 32'h7FFF_FFFF;
            2, 3:    row.t_point = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: row.t_point = $urandom();
         endcase
      end
      return row;
   endfunction

   task automatic push_item(input req_row_t row);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= row.action;
      req_bus.coef_index <= row.index;
      req_bus.coef_value <= row.data[COEF_W-1:0];
      req_bus.t_value    <= row.t_point;
      do @(posedge clock); while (!req_bus.ready);
      if (row.action == ACT_WRITE) begin
         if (int'(row.index) <= TERMS_MAX) coef_shadow[row.index] = row.data[COEF_W-1:0];
      end else begin
         series_due.push_back(row.typed ? row.series : series_at(row.t_point));
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (series_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_NUM_TERMS) terms_shadow = data[NT_W-1:0];
      else if (idx == CSR_TURNS) turns_shadow = data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      int hold_left;
      bit hold_used;
      hold_left     = 0;
      hold_used     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYC;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      logic signed [SERIES_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (series_due.size() == 0) begin
            $error("series_value: unexpected item, actual %0d", rsp_bus.series_value);
            mismatch_count++;
         end else begin
            want = series_due.pop_front();
            if (rsp_bus.series_value !== want) begin
               $error("series_value: expected %0d, actual %0d", want, rsp_bus.series_value);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_row_t          row;
      int                counted;
      logic [NT_W-1:0]   k;
      logic [31:0]       turns;
      logic [31:0]       noise;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_WRITE;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      req_bus.t_value    = '0;
      for (int i = 0; i <= TERMS_MAX; i++) coef_shadow[i] = '0;
      terms_shadow = NT_RESET;
      turns_shadow = TURNS_RESET;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 49;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_csr(plan[i].index[CSR_IDX_W-1:0], plan[i].data);
         end else begin
            push_item(plan[i]);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 49 : 0;
         recv_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 33 : 0;
         case (ph)
            0:       begin k = 5'd2;  turns = TURNS_RESET;   end
            1:       begin k = 5'd16; turns = 32'hFFFF_FFFF; end
            2:       begin k = 5'd31; turns = $urandom();    end
            3:       begin k = 5'($urandom_range(0, 31)); turns = $urandom(); end
            4:       begin k = 5'd8;  turns = $urandom();    end
            default: begin k = 5'($urandom_range(1, 16)); turns = $urandom(); end
         endcase
         noise = $urandom();
         write_csr(CSR_NUM_TERMS, {noise[31:NT_W], k});
         write_csr(CSR_TURNS, turns);
         if (ph == 4) hold_armed = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            row = draw_item();
            push_item(row);
            if (row.action == ACT_EVAL || int'(row.index) <= TERMS_MAX) counted++;
         end
      end

      req_bus.valid <= 1'b0;
      while (series_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYC) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/cse_pkg.sv
rtl/core/cse_ifs.sv
rtl/core/cse_ram.sv
rtl/core/cosine_series_evaluator_top.sv
rtl/core/cse_chk.sv
dv/tb_cosine_series_evaluator_top.sv
